// ----- rtl/shsd_pkg.sv -----
// Package for the stacked hash-set dictionary: types, codes and sizes.
`timescale 1ns / 1ps
`default_nettype none

package shsd_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int COLUMNS_DEF  = 1024;
  localparam int TABLES_DEF   = 2;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths
  localparam int CMD_W = 2;
  localparam int KEY_W = 32;
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

  // Command codes; the two unnamed codes act as a lookup
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Home-column remainder: key bits retired per divider cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = KEY_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Input word
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             found;
    logic             status;
    logic [CFG_W-1:0] stored_count;
  } out_word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ZKEY,
    ST_DIV,
    ST_LOAD,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;      // latch the incoming word
    logic sweep;     // write one zero row, advance sweep column
    logic zkey;      // resolve a zero key against the flag
    logic div_step;  // one divider step
    logic load;      // start the probe at the home column
    logic check;     // examine the row read for the current column
    logic emit;      // load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_clear;     // incoming word is a clear
    logic in_key_zero;  // incoming key is zero after masking
    logic sweep_last;   // sweep is at the last column
    logic div_last;     // divider is in its last cycle
    logic probe_end;    // probe resolves in this cycle
    logic out_free;     // result register can take a word
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/shsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module shsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/shsd_ctrl.sv -----
// Controller state machine for the stacked hash-set dictionary.
`timescale 1ns / 1ps
`default_nettype none

module shsd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire shsd_pkg::dp_stat_t stat_i,
  output shsd_pkg::dp_cmd_t     cmd_o
);

  shsd_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shsd_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shsd_pkg::ST_INIT: begin
        if (stat_i.sweep_last) state_d = shsd_pkg::ST_IDLE;
      end
      shsd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.in_clear)         state_d = shsd_pkg::ST_CLEAR;
          else if (stat_i.in_key_zero) state_d = shsd_pkg::ST_ZKEY;
          else                         state_d = shsd_pkg::ST_DIV;
        end
      end
      shsd_pkg::ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = shsd_pkg::ST_DONE;
      end
      shsd_pkg::ST_ZKEY: begin
        state_d = shsd_pkg::ST_DONE;
      end
      shsd_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = shsd_pkg::ST_LOAD;
      end
      shsd_pkg::ST_LOAD: begin
        state_d = shsd_pkg::ST_CHECK;
      end
      shsd_pkg::ST_CHECK: begin
        if (stat_i.probe_end) state_d = shsd_pkg::ST_DONE;
      end
      shsd_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = shsd_pkg::ST_IDLE;
      end
      default: state_d = shsd_pkg::ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      shsd_pkg::ST_INIT:  cmd_o.sweep = 1'b1;
      shsd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      shsd_pkg::ST_CLEAR: cmd_o.sweep    = 1'b1;
      shsd_pkg::ST_ZKEY:  cmd_o.zkey     = 1'b1;
      shsd_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      shsd_pkg::ST_LOAD:  cmd_o.load     = 1'b1;
      shsd_pkg::ST_CHECK: cmd_o.check    = 1'b1;
      shsd_pkg::ST_DONE:  cmd_o.emit     = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/shsd_dp.sv -----
// Datapath: key tables, home-column divider, probe column, counters, result register.
`timescale 1ns / 1ps
`default_nettype none

module shsd_dp #(
  parameter int COLUMNS  = shsd_pkg::COLUMNS_DEF,
  parameter int TABLES   = shsd_pkg::TABLES_DEF,
  parameter int KEY_BITS = shsd_pkg::KEY_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire shsd_pkg::in_word_t          in_word_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output shsd_pkg::out_word_t              out_word_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [shsd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire shsd_pkg::dp_cmd_t           cmd_i,
  output shsd_pkg::dp_stat_t               stat_o
);

  localparam int CFG_W = shsd_pkg::CFG_W;
  localparam int KEY_W = shsd_pkg::KEY_W;
  localparam int CW    = $clog2(COLUMNS);
  localparam int CXW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int ROW_W = TABLES * KEY_BITS;
  localparam logic [CFG_W-1:0] NCOL_RST =
    (COLUMNS > int'(shsd_pkg::CFG_MAX)) ? shsd_pkg::CFG_MAX : CFG_W'(COLUMNS);

  // Registers
  logic [CFG_W-1:0]              ncol_q;
  logic [CFG_W-1:0]              count_q, count_d;
  logic                          empty_set_q, empty_set_d;
  logic [CXW-1:0]                col_q, col_d;
  logic [CFG_W-1:0]              iter_q, iter_d;
  logic [shsd_pkg::DIV_CNT_W-1:0] step_q, step_d;
  logic [CFG_W-1:0]              rem_q, rem_d;
  logic [KEY_W-1:0]              dvd_q, dvd_d;
  logic [KEY_BITS-1:0]           key_q;
  logic                          ins_q;
  logic                          res_found_q, res_found_d;
  logic                          res_status_q, res_status_d;
  logic                          out_valid_q, out_valid_d;
  shsd_pkg::out_word_t           out_word_q;

  // Combinational
  logic [CFG_W-1:0]    n;
  logic [KEY_BITS-1:0] key_m;
  logic [KEY_W-1:0]    dvd_m;
  logic [ROW_W-1:0]    rdata;
  logic [ROW_W-1:0]    wdata;
  logic                we;
  logic                hit, hit_key;
  logic [TW-1:0]       hit_t;
  logic [CXW:0]        col_inc;
  logic [CXW-1:0]      col_wrap;
  logic                exhausted;
  logic                room;

  // Columns in use: zero reads as one, above the table size as the table size
  always_comb begin
    if (ncol_q == '0) begin
      n = CFG_W'(1);
    end else if (32'(ncol_q) > COLUMNS) begin
      n = CFG_W'(COLUMNS);
    end else begin
      n = ncol_q;
    end
  end

  // Key masked to KEY_BITS: table form and divider form
  always_comb begin
    for (int b = 0; b < KEY_BITS; b++) begin
      key_m[b] = (b < KEY_W) ? in_word_i.key[b % KEY_W] : 1'b0;
    end
    for (int b = 0; b < KEY_W; b++) begin
      dvd_m[b] = (b < KEY_BITS) ? in_word_i.key[b] : 1'b0;
    end
  end

  // Home-column divider: DIV_BITS restoring steps per cycle
  always_comb begin
    logic [CFG_W:0]   t;
    logic [CFG_W-1:0] r;
    logic [KEY_W-1:0] d;
    r = rem_q;
    d = dvd_q;
    for (int k = 0; k < shsd_pkg::DIV_BITS; k++) begin
      t = {r, d[KEY_W-1]};
      d = {d[KEY_W-2:0], 1'b0};
      if (t >= {1'b0, n}) r = CFG_W'(t - {1'b0, n});
      else                r = t[CFG_W-1:0];
    end
    rem_d = rem_q;
    dvd_d = dvd_q;
    step_d = step_q;
    if (cmd_i.take) begin
      rem_d  = '0;
      dvd_d  = dvd_m;
      step_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d  = r;
      dvd_d  = d;
      step_d = step_q + 1'b1;
    end
  end

  // Row check: first table whose slot holds the key or is empty
  always_comb begin
    logic [KEY_BITS-1:0] slot;
    hit     = 1'b0;
    hit_key = 1'b0;
    hit_t   = '0;
    for (int t = TABLES - 1; t >= 0; t--) begin
      slot = rdata[t*KEY_BITS +: KEY_BITS];
      if (slot == key_q || slot == '0) begin
        hit     = 1'b1;
        hit_key = (slot == key_q);
        hit_t   = TW'(t);
      end
    end
  end

  // Row to write back: all zeros in a sweep, else the hit slot replaced by the key
  always_comb begin
    for (int t = 0; t < TABLES; t++) begin
      wdata[t*KEY_BITS +: KEY_BITS] =
        (cmd_i.sweep || TW'(t) != hit_t) ? (cmd_i.sweep ? '0 : rdata[t*KEY_BITS +: KEY_BITS])
                                         : key_q;
    end
  end

  assign exhausted = (iter_q == n - CFG_W'(1));
  assign room      = (count_q < n);
  assign col_inc   = {1'b0, col_q} + (CXW+1)'(1);
  assign col_wrap  = (col_inc >= (CXW+1)'(n)) ? '0 : col_inc[CXW-1:0];
  assign we        = cmd_i.sweep ||
                     (cmd_i.check && ins_q && hit && !hit_key && room);

  // Probe column, sweep column and probe length
  always_comb begin
    col_d  = col_q;
    iter_d = iter_q;
    if (cmd_i.take) begin
      col_d = '0;
    end else if (cmd_i.sweep) begin
      col_d = col_inc[CXW-1:0];
    end else if (cmd_i.load) begin
      col_d  = CXW'(rem_q);
      iter_d = '0;
    end else if (cmd_i.check && !(hit || exhausted)) begin
      col_d  = col_wrap;
      iter_d = iter_q + 1'b1;
    end
  end

  // Count, zero-key flag and result bits
  always_comb begin
    count_d      = count_q;
    empty_set_d  = empty_set_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    if (cmd_i.sweep) begin
      count_d      = '0;
      empty_set_d  = 1'b0;
      res_found_d  = 1'b0;
      res_status_d = 1'b0;
    end else if (cmd_i.zkey) begin
      res_found_d  = empty_set_q;
      res_status_d = 1'b0;
      if (ins_q) empty_set_d = 1'b1;
    end else if (cmd_i.check && (hit || exhausted)) begin
      res_found_d  = hit && hit_key;
      res_status_d = ins_q && !(hit && hit_key) && (!hit || !room);
      if (we) count_d = count_q + 1'b1;
    end
  end

  // Result register; a stalled word holds
  assign out_valid_d = cmd_i.emit || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncol_q      <= NCOL_RST;
      count_q     <= '0;
      empty_set_q <= 1'b0;
      col_q       <= '0;
      iter_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) ncol_q <= cfg_wdata_i;
      count_q     <= count_d;
      empty_set_q <= empty_set_d;
      col_q       <= col_d;
      iter_q      <= iter_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    dvd_q        <= dvd_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    if (cmd_i.take) begin
      key_q <= key_m;
      ins_q <= (in_word_i.cmd == shsd_pkg::CMD_INSERT);
    end
    if (cmd_i.emit) begin
      out_word_q.found        <= res_found_q;
      out_word_q.status       <= res_status_q;
      out_word_q.stored_count <= count_q;
    end
  end

  // Key tables: one row per column, all tables side by side
  shsd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (COLUMNS)
  ) u_tables (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (col_q[CW-1:0]),
    .wdata_i (wdata),
    .raddr_i (col_d[CW-1:0]),
    .rdata_o (rdata)
  );

  // Status
  assign stat_o.in_clear    = (in_word_i.cmd == shsd_pkg::CMD_CLEAR);
  assign stat_o.in_key_zero = (key_m == '0);
  assign stat_o.sweep_last  = (col_q == CXW'(COLUMNS - 1));
  assign stat_o.div_last    = (step_q == shsd_pkg::DIV_CNT_W'(shsd_pkg::DIV_STEPS - 1));
  assign stat_o.probe_end   = hit || exhausted;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ----- rtl/stacked_hash_set_dictionary.sv -----
// Top level of the stacked hash-set dictionary.
//
//  channel  direction  handshake                 word
//  -------  ---------  ------------------------  ------------------------------
//  in       input      in_valid_i/in_stall_o     in_word_i  (cmd, key)
//  out      output     out_valid_o/out_stall_i   out_word_o (found, status,
//                                                            stored_count)
//  cfg      input      cfg_we_i                  cfg_wdata_i (num_columns)
//
// A nonzero key is accepted, its home-column remainder is formed (4 key
// bits a cycle), the probe starts and visits one column after another (all
// tables of a column share one RAM row), and the result is posted. A zero key
// is checked against a flag; a clear sweeps all COLUMNS rows, one a cycle; the same
// sweep follows reset with no word accepted. A result waits in the output
// register while the next word is taken; a second result waits for it to leave.
`timescale 1ns / 1ps
`default_nettype none

module stacked_hash_set_dictionary #(
  parameter int COLUMNS  = shsd_pkg::COLUMNS_DEF,
  parameter int TABLES   = shsd_pkg::TABLES_DEF,
  parameter int KEY_BITS = shsd_pkg::KEY_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire shsd_pkg::in_word_t         in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output shsd_pkg::out_word_t             out_word_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [shsd_pkg::CFG_W-1:0] cfg_wdata_i
);

  shsd_pkg::dp_cmd_t  dp_cmd;
  shsd_pkg::dp_stat_t dp_stat;

  // Controller
  shsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath
  shsd_dp #(
    .COLUMNS  (COLUMNS),
    .TABLES   (TABLES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the stacked hash-set dictionary: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import shsd_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 42;
  localparam int HOLD_PHASE      = 3;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int POOL_MAX        = 64;

  // Column settings per random phase and whether the phase starts with a clear
  localparam int PHASE_COLS  [NUM_PHASES] = '{13, 1, 0, 7, 2, 1024, 2047, 31, 5, 3, 97, 1024};
  localparam int PHASE_CLEAR [NUM_PHASES] = '{1, 0, 1, 0, 1, 1, 0, 0, 1, 0, 1, 0};

  typedef enum int {PROBE_HIT, PROBE_EMPTY, PROBE_NONE} probe_e;
  typedef enum int {MODE_SEND_LIGHT, MODE_SEND_HEAVY, MODE_NO_IDLE} idle_mode_e;

  typedef struct {
    logic             is_cfg;
    logic [CFG_W-1:0] cfg_val;
    in_word_t         word;
    logic             typed;
    out_word_t        reply;
  } dir_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_word_t         in_word_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_word_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             hold_go     = 1'b0;

  // Predictor state
  logic [KEY_W-1:0] slot_key [TABLES_DEF][COLUMNS_DEF];
  logic [CFG_W-1:0] key_count  = '0;
  logic             zero_held  = 1'b0;
  logic [CFG_W-1:0] cfg_columns = CFG_W'(COLUMNS_DEF);

  out_word_t        pending_replies [$];
  logic [KEY_W-1:0] key_pool [$];
  idle_mode_e       idle_mode = MODE_SEND_LIGHT;

  int n_errors  = 0;
  int n_checked = 0;
  int n_sent    = 0;
  int n_hits    = 0;
  int n_refused = 0;
  int n_clears  = 0;
  int n_held    = 0;

  always #5 clk_i = ~clk_i;

  stacked_hash_set_dictionary DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Effective column count: zero acts as one, oversize clamps
  function automatic int unsigned cols_in_use();
    if (cfg_columns == '0) return 1;
    if (cfg_columns > CFG_W'(COLUMNS_DEF)) return COLUMNS_DEF;
    return cfg_columns;
  endfunction

  function automatic int unsigned tx_idle_pct();
    case (idle_mode)
      MODE_SEND_LIGHT: return 31;
      MODE_SEND_HEAVY: return 59;
      default:         return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct();
    case (idle_mode)
      MODE_SEND_LIGHT: return 59;
      MODE_SEND_HEAVY: return 31;
      default:         return 0;
    endcase
  endfunction

  // Walk from the home column, all tables per column, stop at key or empty slot
  function automatic probe_e probe_key(input logic [KEY_W-1:0] k, output int unsigned tab,
                                       output int unsigned col);
    int unsigned n, c, i, t;
    n = cols_in_use();
    c = k % n;
    tab = 0;
    col = 0;
    for (i = 0; i < n; i++) begin
      for (t = 0; t < TABLES_DEF; t++) begin
        if (slot_key[t][c] == k || slot_key[t][c] == '0) begin
          tab = t;
          col = c;
          if (slot_key[t][c] == k) return PROBE_HIT;
          return PROBE_EMPTY;
        end
      end
      c = (c + 1 >= n) ? 0 : c + 1;
    end
    return PROBE_NONE;
  endfunction

  // Apply one command to the predicted dictionary, return its reply
  function automatic out_word_t predict_reply(input in_word_t w);
    out_word_t   r;
    probe_e      hit;
    int unsigned t, c;
    r = '0;
    if (w.cmd == CMD_CLEAR) begin
      for (t = 0; t < TABLES_DEF; t++)
        for (c = 0; c < COLUMNS_DEF; c++) slot_key[t][c] = '0;
      key_count = '0;
      zero_held = 1'b0;
      n_clears++;
    end else if (w.key == '0) begin
      // empty set lives in a flag, not in the tables
      r.found = zero_held;
      if (w.cmd == CMD_INSERT) zero_held = 1'b1;
    end else begin
      hit = probe_key(w.key, t, c);
      if (hit == PROBE_HIT) begin
        r.found = 1'b1;
        n_hits++;
      end else if (w.cmd == CMD_INSERT) begin
        if (hit == PROBE_NONE || key_count >= CFG_W'(cols_in_use())) begin
          r.status = 1'b1;
          n_refused++;
        end else begin
          slot_key[t][c] = w.key;
          key_count++;
        end
      end
    end
    r.stored_count = key_count;
    return r;
  endfunction

  // Random command; keys mix zero, reused, clustered and full-width values
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned r, n;
    n = cols_in_use();
    r = $urandom_range(99);
    if (r < 2)       w.cmd = CMD_CLEAR;
    else if (r < 7)  w.cmd = CMD_SPARE;
    else if (r < 52) w.cmd = CMD_INSERT;
    else             w.cmd = CMD_LOOKUP;
    r = $urandom_range(99);
    if (r < 6) w.key = '0;
    else if (r < 50 && key_pool.size() != 0)
      w.key = key_pool[$urandom_range(key_pool.size() - 1)];
    else if (r < 75) w.key = $urandom_range(4 * n, 1);
    else w.key = $urandom;
    if (w.cmd == CMD_INSERT && w.key != '0) begin
      if (key_pool.size() < POOL_MAX) key_pool.push_back(w.key);
      else key_pool[$urandom_range(POOL_MAX - 1)] = w.key;
    end
    return w;
  endfunction

  function automatic dir_row_t item_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                        input logic typed, input logic f, input logic s,
                                        input int cnt);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = '0;
    row.word.cmd = cmd;
    row.word.key = key;
    row.typed = typed;
    row.reply.found = f;
    row.reply.status = s;
    row.reply.stored_count = CFG_W'(cnt);
    return row;
  endfunction

  // Offer one word, wait for acceptance, queue its expected reply
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t typed_reply);
    out_word_t pred;
    if (tx_idle_pct() != 0 && $urandom_range(99) < tx_idle_pct()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct());
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = predict_reply(w);
    pending_replies.push_back(typed ? typed_reply : pred);
    n_sent++;
  endtask

  // Stop offering and wait until every reply is back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_columns(input logic [CFG_W-1:0] v);
    drain_replies();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_columns = v;
    @(posedge clk_i);
  endtask

  // Receiver: random stall, plus one long hold-off when requested
  initial begin : reply_sink
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        n_held++;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (rx_idle_pct() != 0 && $urandom_range(99) < rx_idle_pct());
      end
    end
  end

  // Compare each accepted reply with the oldest expectation
  always @(posedge clk_i) begin : reply_check
    out_word_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_replies.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected reply: found=%0d status=%0d count=%0d",
                   out_word_o.found, out_word_o.status, out_word_o.stored_count);
      end else begin
        want = pending_replies.pop_front();
        n_checked++;
        if (out_word_o.found !== want.found || out_word_o.status !== want.status ||
            out_word_o.stored_count !== want.stored_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display("reply %0d mismatch: expected found=%0d status=%0d count=%0d, got %0d %0d %0d",
                     n_checked, want.found, want.status, want.stored_count,
                     out_word_o.found, out_word_o.status, out_word_o.stored_count);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t  dir_rows [$];
    out_word_t no_reply;
    in_word_t  clr;
    int        p, i;
    no_reply = '0;
    clr.cmd = CMD_CLEAR;
    clr.key = '0;

    // At reset: empty dictionary, zero key flag, extremes, collisions and wrap
    dir_rows.push_back(item_row(CMD_LOOKUP, 32'h0000_0000, 1, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_LOOKUP, 32'hFFFF_FFFF, 1, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_INSERT, 32'h0000_0000, 1, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_INSERT, 32'h0000_0000, 1, 1, 0, 0));
    dir_rows.push_back(item_row(CMD_SPARE,  32'h0000_0000, 1, 1, 0, 0));
    dir_rows.push_back(item_row(CMD_INSERT, 32'hFFFF_FFFF, 1, 0, 0, 1));
    dir_rows.push_back(item_row(CMD_INSERT, 32'hFFFF_FFFF, 1, 1, 0, 1));
    dir_rows.push_back(item_row(CMD_SPARE,  32'hFFFF_FFFF, 1, 1, 0, 1));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd1,         1, 0, 0, 2));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd1025,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd2049,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_LOOKUP, 32'd2049,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_LOOKUP, 32'd3073,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd1023,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd2047,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd3071,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_LOOKUP, 32'd3071,      0, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_CLEAR,  32'hFFFF_FFFF, 1, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_LOOKUP, 32'hFFFF_FFFF, 1, 0, 0, 0));
    dir_rows.push_back(item_row(CMD_LOOKUP, 32'h0000_0000, 1, 0, 0, 0));
    // One column: full refusal, present key while full, zero key while full
    dir_rows.push_back(item_row(CMD_LOOKUP, '0, 0, 0, 0, 0));
    dir_rows[$].is_cfg = 1'b1;
    dir_rows[$].cfg_val = CFG_W'(1);
    dir_rows.push_back(item_row(CMD_INSERT, 32'd5, 1, 0, 0, 1));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd6, 1, 0, 1, 1));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd5, 1, 1, 0, 1));
    dir_rows.push_back(item_row(CMD_INSERT, 32'd0, 1, 0, 0, 1));
    dir_rows.push_back(item_row(CMD_CLEAR,  32'd0, 1, 0, 0, 0));

    for (p = 0; p < TABLES_DEF; p++)
      for (i = 0; i < COLUMNS_DEF; i++) slot_key[p][i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) write_columns(dir_rows[r].cfg_val);
      else send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].reply);
    end
    drain_replies();

    // Random phases; some keep stale keys across a column change
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p / 4)
        0:       idle_mode = MODE_SEND_LIGHT;
        1:       idle_mode = MODE_SEND_HEAVY;
        default: idle_mode = MODE_NO_IDLE;
      endcase
      write_columns(CFG_W'(PHASE_COLS[p]));
      if (PHASE_CLEAR[p] != 0) send_word(clr, 1'b0, no_reply);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == HOLD_PHASE && i == 3) hold_go <= 1'b1;
        send_word(random_word(), 1'b0, no_reply);
      end
      drain_replies();
    end

    drain_replies();
    repeat (50) @(posedge clk_i);
    if (pending_replies.size() != 0) n_errors++;

    $display("covered %0d words, %0d replies checked, %0d column settings",
             n_sent, n_checked, NUM_PHASES + 2);
    $display("%0d hits, %0d refused inserts, %0d clears, receiver held off %0d cycles",
             n_hits, n_refused, n_clears, n_held);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Run-time limit
  initial begin : watchdog
    #40_000_000;
    $display("timeout with %0d replies outstanding", pending_replies.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- stacked_hash_set_dictionary.f -----
rtl/shsd_pkg.sv
rtl/shsd_ram.sv
rtl/shsd_ctrl.sv
rtl/shsd_dp.sv
rtl/stacked_hash_set_dictionary.sv
bench/testbench.sv
